/* rtl/core/tagged_open_address_hash_table_macros.svh */
// Assertion macros shared by the hash table checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef TAGGED_OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define TAGGED_OPEN_ADDRESS_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TOAH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TOAH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/toah_pkg.sv */
// Types and constants of the tagged open-address hash table.
// Used by the cells, the top level and the checker; depends on nothing.
package toah_pkg;

   localparam int DEFAULT_SLOTS      = 1024;
   localparam int DEFAULT_KEY_BITS   = 64;
   localparam int DEFAULT_VALUE_BITS = 64;

   // Tags read per row of the tag memory, one per cell.
   localparam int LANES  = 16;
   localparam int LANE_W = $clog2(LANES);

   localparam logic [7:0] EMPTY_TAG = 8'h00;
   localparam logic [7:0] TAG_SUBST = 8'hA5;

   typedef enum logic [1:0] {
      OP_FIND        = 2'd0,
      OP_INS_REPLACE = 2'd1,
      OP_INS_UNIQUE  = 2'd2,
      OP_DELETE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXISTS    = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TAG_CHECK,
      ST_KEY_ISSUE,
      ST_KEY_CHECK,
      ST_FINISH,
      ST_TAG_WRITE,
      ST_RESPOND
   } state_type;

   // Priority chain carried from one cell to the next.
   typedef struct packed {
      logic cand_seen;
      logic empty_seen;
   } chain_type;

   // Controls broadcast to every cell.
   typedef struct packed {
      logic load;
      logic reject;
   } cell_ctrl_type;

endpackage

/* rtl/core/tagged_open_address_hash_table.sv */
// Tagged open-address hash table with linear probing.
// A request visits tag rows, compares the key of each tag match, finishes, writes the tag
// row back when an entry is added or deleted, and responds; a miss visits SLOTS/16 + 1 rows.
// One transaction is in flight at a time and the next is accepted while the result is offered.
// After reset a clearing pass writes SLOTS/16 rows before req_stall drops.
module tagged_open_address_hash_table #(
   parameter int SLOTS      = toah_pkg::DEFAULT_SLOTS,
   parameter int KEY_BITS   = toah_pkg::DEFAULT_KEY_BITS,
   parameter int VALUE_BITS = toah_pkg::DEFAULT_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [31:0] req_hash_value,
   input  logic [63:0] req_key_word,
   input  logic [63:0] req_value_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_hit,
   output logic [63:0] rsp_found_value,
   output logic [9:0]  rsp_slot_index,
   output logic [10:0] rsp_entry_count
);

   localparam int LANES  = toah_pkg::LANES;
   localparam int LANE_W = toah_pkg::LANE_W;
   localparam int ROWS   = (SLOTS + LANES - 1) / LANES;
   localparam int ROW_W  = ROWS > 1 ? $clog2(ROWS) : 1;
   localparam int VIS_W  = $clog2(ROWS + 1);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   toah_pkg::state_type state_ff, state_in;
   toah_pkg::op_type    op_ff, op_in;
   logic [7:0]            tag_ff, tag_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [LANE_W-1:0]     lane0_ff, lane0_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [ROW_W-1:0]      clr_ff, clr_in;
   logic [VIS_W-1:0]      visit_ff, visit_in;
   logic                  match_ff, match_in;
   logic [SLOT_W-1:0]     match_slot_ff, match_slot_in;
   logic                  empty_found_ff, empty_found_in;
   logic [SLOT_W-1:0]     empty_slot_ff, empty_slot_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]     wr_slot_ff, wr_slot_in;
   logic [7:0]            wr_tag_ff, wr_tag_in;
   toah_pkg::status_type  res_status_ff, res_status_in;
   logic                  res_hit_ff, res_hit_in;
   logic [63:0]           res_fval_ff, res_fval_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   toah_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [63:0]           rsp_fval_ff, rsp_fval_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // Memory ports.
   logic                    tag_wr_en, tag_rd_en;
   logic [ROW_W-1:0]        tag_wr_addr, tag_rd_addr;
   logic [LANES*8-1:0]      tag_wr_data, tag_rd_data, tag_row_mod;
   logic                    kv_wr_en, key_rd_en, val_rd_en;
   logic [SLOT_W-1:0]       kv_wr_addr, kv_rd_addr;
   logic [KEY_BITS-1:0]     key_wr_data, key_rd_data;
   logic [VALUE_BITS-1:0]   val_wr_data, val_rd_data;

   // Cell row signals.
   toah_pkg::cell_ctrl_type ctrl;
   toah_pkg::chain_type     chain [LANES+1];
   logic [LANES-1:0]        lane_en, pick, empty_pick;
   logic [LANE_W-1:0]       pick_lane, empty_lane;
   logic                    any_pick, any_empty;
   logic [SLOT_W-1:0]       cur_slot;

   // Start slot from the top hash bits, reduced once when SLOTS is not a power of two.
   logic [7:0]        req_tag;
   logic [SLOT_W-1:0] start_top, start_slot, start_row_wide;
   logic [ROW_W-1:0]  wr_row;
   logic [LANE_W-1:0] wr_lane;

   assign req_tag   = (req_hash_value[7:0] == toah_pkg::EMPTY_TAG) ?
                      toah_pkg::TAG_SUBST : req_hash_value[7:0];
   assign start_top = req_hash_value[31 -: SLOT_W];
   assign start_slot = ({1'b0, start_top} >= (SLOT_W + 1)'(SLOTS)) ?
                       start_top - SLOT_W'(SLOTS) : start_top;
   assign start_row_wide = start_slot >> LANE_W;

   assign wr_row  = ROW_W'(wr_slot_ff >> LANE_W);
   assign wr_lane = wr_slot_ff[LANE_W-1:0];

   // Lanes taking part in the current row visit.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_en[i] = (({row_ff, LANE_W'(i)}) < (ROW_W + LANE_W + 1)'(SLOTS));
         if (visit_ff == '0) begin
            lane_en[i] = lane_en[i] && (LANE_W'(i) >= lane0_ff);
         end else if (visit_ff == VIS_W'(ROWS)) begin
            lane_en[i] = lane_en[i] && (LANE_W'(i) < lane0_ff);
         end
      end
   end

   assign chain[0] = '0;

   for (genvar g = 0; g < LANES; g++) begin : g_cell
      toah_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .lane_en    (lane_en[g]),
         .lane_tag   (tag_rd_data[g*8 +: 8]),
         .search_tag (tag_ff),
         .chain_in   (chain[g]),
         .chain_out  (chain[g+1]),
         .pick       (pick[g]),
         .empty_pick (empty_pick[g])
      );
   end

   // One-hot lane selects to lane numbers.
   always_comb begin
      pick_lane  = '0;
      empty_lane = '0;
      for (int i = 0; i < LANES; i++) begin
         if (pick[i]) begin
            pick_lane = pick_lane | LANE_W'(i);
         end
         if (empty_pick[i]) begin
            empty_lane = empty_lane | LANE_W'(i);
         end
      end
   end

   assign any_pick  = chain[LANES].cand_seen;
   assign any_empty = chain[LANES].empty_seen;
   assign cur_slot  = SLOT_W'({row_ff, pick_lane});

   // Tag row with one lane replaced, for the tag write-back.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         tag_row_mod[i*8 +: 8] = (LANE_W'(i) == wr_lane) ? wr_tag_ff : tag_rd_data[i*8 +: 8];
      end
   end

   toah_ram #(.WIDTH(LANES * 8), .DEPTH(ROWS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_en   (tag_rd_en),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   toah_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (kv_wr_en),
      .wr_addr (kv_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (kv_rd_addr),
      .rd_data (key_rd_data)
   );

   toah_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
      .clock   (clock),
      .wr_en   (kv_wr_en),
      .wr_addr (kv_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (val_rd_en),
      .rd_addr (kv_rd_addr),
      .rd_data (val_rd_data)
   );

   // Sequencer: next state, memory controls and result bookkeeping.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      tag_in         = tag_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      lane0_in       = lane0_ff;
      row_in         = row_ff;
      clr_in         = clr_ff;
      visit_in       = visit_ff;
      match_in       = match_ff;
      match_slot_in  = match_slot_ff;
      empty_found_in = empty_found_ff;
      empty_slot_in  = empty_slot_ff;
      count_in       = count_ff;
      wr_slot_in     = wr_slot_ff;
      wr_tag_in      = wr_tag_ff;
      res_status_in  = res_status_ff;
      res_hit_in     = res_hit_ff;
      res_fval_in    = res_fval_ff;
      res_slot_in    = res_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_fval_in    = rsp_fval_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_count_in   = rsp_count_ff;
      tag_wr_en      = 1'b0;
      tag_wr_addr    = clr_ff;
      tag_wr_data    = '0;
      tag_rd_en      = 1'b0;
      tag_rd_addr    = row_ff;
      kv_wr_en       = 1'b0;
      kv_wr_addr     = match_slot_ff;
      key_wr_data    = key_ff;
      val_wr_data    = val_ff;
      key_rd_en      = 1'b0;
      val_rd_en      = 1'b0;
      kv_rd_addr     = cur_slot;
      ctrl           = '0;
      req_stall      = 1'b1;

      case (state_ff)
         toah_pkg::ST_CLEAR: begin
            tag_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = toah_pkg::ST_IDLE;
            end
         end
         toah_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in          = toah_pkg::op_type'(req_operation);
               tag_in         = req_tag;
               key_in         = req_key_word[KEY_BITS-1:0];
               val_in         = req_value_word[VALUE_BITS-1:0];
               lane0_in       = start_slot[LANE_W-1:0];
               row_in         = ROW_W'(start_row_wide);
               visit_in       = '0;
               match_in       = 1'b0;
               empty_found_in = 1'b0;
               tag_rd_en      = 1'b1;
               tag_rd_addr    = ROW_W'(start_row_wide);
               state_in       = toah_pkg::ST_TAG_CHECK;
            end
         end
         toah_pkg::ST_TAG_CHECK: begin
            ctrl.load = 1'b1;
            if (!empty_found_ff && any_empty) begin
               empty_found_in = 1'b1;
               empty_slot_in  = SLOT_W'({row_ff, empty_lane});
            end
            state_in = toah_pkg::ST_KEY_ISSUE;
         end
         toah_pkg::ST_KEY_ISSUE: begin
            if (any_pick) begin
               key_rd_en = 1'b1;
               state_in  = toah_pkg::ST_KEY_CHECK;
            end else if (visit_ff == VIS_W'(ROWS)) begin
               state_in = toah_pkg::ST_FINISH;
            end else begin
               // Move on to the next row, wrapping to row zero.
               visit_in    = visit_ff + 1'b1;
               row_in      = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
               tag_rd_en   = 1'b1;
               tag_rd_addr = row_in;
               state_in    = toah_pkg::ST_TAG_CHECK;
            end
         end
         toah_pkg::ST_KEY_CHECK: begin
            if (key_rd_data == key_ff) begin
               match_in      = 1'b1;
               match_slot_in = cur_slot;
               val_rd_en     = 1'b1;
               state_in      = toah_pkg::ST_FINISH;
            end else begin
               ctrl.reject = 1'b1;
               state_in    = toah_pkg::ST_KEY_ISSUE;
            end
         end
         toah_pkg::ST_FINISH: begin
            res_status_in = toah_pkg::STATUS_OK;
            res_hit_in    = match_ff;
            res_fval_in   = '0;
            res_slot_in   = match_ff ? match_slot_ff : '0;
            state_in      = toah_pkg::ST_RESPOND;
            case (op_ff)
               toah_pkg::OP_FIND: begin
                  if (match_ff) begin
                     res_fval_in = 64'(val_rd_data);
                  end else begin
                     res_status_in = toah_pkg::STATUS_NOT_FOUND;
                  end
               end
               toah_pkg::OP_INS_REPLACE, toah_pkg::OP_INS_UNIQUE: begin
                  if (match_ff) begin
                     if (op_ff == toah_pkg::OP_INS_UNIQUE) begin
                        res_status_in = toah_pkg::STATUS_EXISTS;
                     end else begin
                        kv_wr_en = 1'b1;
                     end
                  end else if (count_ff >= CNT_W'(SLOTS) || !empty_found_ff) begin
                     res_status_in = toah_pkg::STATUS_FULL;
                  end else begin
                     // New entry in the first empty slot of the probe.
                     kv_wr_en    = 1'b1;
                     kv_wr_addr  = empty_slot_ff;
                     count_in    = count_ff + 1'b1;
                     res_slot_in = empty_slot_ff;
                     wr_slot_in  = empty_slot_ff;
                     wr_tag_in   = tag_ff;
                     tag_rd_en   = 1'b1;
                     tag_rd_addr = ROW_W'(empty_slot_ff >> LANE_W);
                     state_in    = toah_pkg::ST_TAG_WRITE;
                  end
               end
               default: begin
                  if (match_ff) begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     wr_slot_in  = match_slot_ff;
                     wr_tag_in   = toah_pkg::EMPTY_TAG;
                     tag_rd_en   = 1'b1;
                     tag_rd_addr = ROW_W'(match_slot_ff >> LANE_W);
                     state_in    = toah_pkg::ST_TAG_WRITE;
                  end else begin
                     res_status_in = toah_pkg::STATUS_NOT_FOUND;
                  end
               end
            endcase
         end
         toah_pkg::ST_TAG_WRITE: begin
            tag_wr_en   = 1'b1;
            tag_wr_addr = wr_row;
            tag_wr_data = tag_row_mod;
            state_in    = toah_pkg::ST_RESPOND;
         end
         toah_pkg::ST_RESPOND: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_hit_in    = res_hit_ff;
               rsp_fval_in   = res_fval_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_count_in  = count_ff;
               state_in      = toah_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = toah_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= toah_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      tag_ff         <= tag_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      lane0_ff       <= lane0_in;
      row_ff         <= row_in;
      visit_ff       <= visit_in;
      match_ff       <= match_in;
      match_slot_ff  <= match_slot_in;
      empty_found_ff <= empty_found_in;
      empty_slot_ff  <= empty_slot_in;
      wr_slot_ff     <= wr_slot_in;
      wr_tag_ff      <= wr_tag_in;
      res_status_ff  <= res_status_in;
      res_hit_ff     <= res_hit_in;
      res_fval_ff    <= res_fval_in;
      res_slot_ff    <= res_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_fval_ff    <= rsp_fval_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_found_value = rsp_fval_ff;
   assign rsp_slot_index  = 10'(rsp_slot_ff);
   assign rsp_entry_count = 11'(rsp_count_ff);

endmodule

/* rtl/core/toah_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module toah_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/toah_cell.sv */
// One lane cell: compares its tag, holds its pending-candidate bit and
// passes the first-found chain to the next cell. Depends on toah_pkg.
module toah_cell (
   input  logic                   clock,
   input  toah_pkg::cell_ctrl_type ctrl,
   input  logic                   lane_en,
   input  logic [7:0]             lane_tag,
   input  logic [7:0]             search_tag,
   input  toah_pkg::chain_type    chain_in,
   output toah_pkg::chain_type    chain_out,
   output logic                   pick,
   output logic                   empty_pick
);

   logic cand_ff;
   logic cand_in;
   logic empty_now;

   assign empty_now = lane_en && (lane_tag == toah_pkg::EMPTY_TAG);

   // First pending candidate and first empty lane along the chain.
   assign pick       = cand_ff && !chain_in.cand_seen;
   assign empty_pick = empty_now && !chain_in.empty_seen;
   assign chain_out.cand_seen  = chain_in.cand_seen || cand_ff;
   assign chain_out.empty_seen = chain_in.empty_seen || empty_now;

   // A candidate is loaded on tag match and dropped once its key misses.
   always_comb begin
      cand_in = cand_ff;
      if (ctrl.load) begin
         cand_in = lane_en && (lane_tag == search_tag);
      end else if (ctrl.reject && pick) begin
         cand_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

endmodule

/* rtl/core/toah_checker.sv */
// Port-level checker for the hash table, bound to the top level.
// Depends on toah_pkg and the assertion macro header.
`include "tagged_open_address_hash_table_macros.svh"

module toah_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_hit,
   input logic [63:0] rsp_found_value,
   input logic [9:0]  rsp_slot_index
);

   logic rsp_miss;
   logic rsp_find_ok;
   logic rsp_has_value;

   // Result classes used by the checks below.
   assign rsp_miss      = (rsp_status == toah_pkg::STATUS_NOT_FOUND) ||
                          (rsp_status == toah_pkg::STATUS_FULL);
   assign rsp_find_ok   = rsp_hit && (rsp_status == toah_pkg::STATUS_OK);
   assign rsp_has_value = (rsp_found_value != '0);

   // A waiting result stays offered until it is taken.
   `TOAH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped")

   // Only one transaction is worked on at a time.
   `TOAH_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "overlap")

   // Misses and a full table report no hit and no slot.
   `TOAH_ASSERT_NOW(a_miss_clean, clock, reset, rsp_valid && rsp_miss, !rsp_hit && rsp_slot_index == '0, "miss")

   // A returned value only comes from a successful find.
   `TOAH_ASSERT_NOW(a_value_on_hit, clock, reset, rsp_valid && rsp_has_value, rsp_find_ok, "stray value")

endmodule

bind tagged_open_address_hash_table toah_checker u_toah_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_hit         (rsp_hit),
   .rsp_found_value (rsp_found_value),
   .rsp_slot_index  (rsp_slot_index)
);
